/* rtl/core/cbet_pkg.sv */
// ----------------------------------------------------------------------------
// cbet_pkg
// Shared types and constants for the channel band entry trigger.
// ----------------------------------------------------------------------------
package cbet_pkg;

  localparam int unsigned MaxRange = 512;

  localparam int unsigned ChannelWidth = 16;
  localparam int unsigned LevelWidth   = 8;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRuleEnabled    = 3'd0,
    CfgFirstChannel   = 3'd1,
    CfgLastChannel    = 3'd2,
    CfgBandLow        = 3'd3,
    CfgBandHigh       = 3'd4,
    CfgCooldownMs     = 3'd5,
    CfgContinuousMode = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                    rule_enabled;
    logic [ChannelWidth-1:0] first_channel;
    logic [ChannelWidth-1:0] last_channel;
    logic [LevelWidth-1:0]   band_low;
    logic [LevelWidth-1:0]   band_high;
    logic [TimeWidth-1:0]    cooldown_ms;
    logic                    continuous_mode;
  } cfg_t;

endpackage

/* rtl/core/cbet_ram.sv */
// ----------------------------------------------------------------------------
// cbet_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cbet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cbet_cfg.sv */
// ----------------------------------------------------------------------------
// cbet_cfg
// Configuration register file, written by index over its own channel.
// ----------------------------------------------------------------------------
module cbet_cfg
  import cbet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRuleEnabled:    cfg_d.rule_enabled    = cfg_data_i[0];
        CfgFirstChannel:   cfg_d.first_channel   = cfg_data_i[ChannelWidth-1:0];
        CfgLastChannel:    cfg_d.last_channel    = cfg_data_i[ChannelWidth-1:0];
        CfgBandLow:        cfg_d.band_low        = cfg_data_i[LevelWidth-1:0];
        CfgBandHigh:       cfg_d.band_high       = cfg_data_i[LevelWidth-1:0];
        CfgCooldownMs:     cfg_d.cooldown_ms     = cfg_data_i[TimeWidth-1:0];
        CfgContinuousMode: cfg_d.continuous_mode = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rule_enabled    <= 1'b0;
      cfg_q.first_channel   <= ChannelWidth'(1);
      cfg_q.last_channel    <= ChannelWidth'(1);
      cfg_q.band_low        <= LevelWidth'(1);
      cfg_q.band_high       <= LevelWidth'(255);
      cfg_q.cooldown_ms     <= TimeWidth'(1000);
      cfg_q.continuous_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/cbet_eval.sv */
// ----------------------------------------------------------------------------
// cbet_eval
// Fire decision for one watched value, with the cooldown timer and the
// fire counter.
// ----------------------------------------------------------------------------
module cbet_eval
  import cbet_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  advance_i,
  input  logic                  in_range_i,
  input  logic [LevelWidth-1:0] level_i,
  input  logic [LevelWidth-1:0] prev_level_i,
  input  logic [TimeWidth-1:0]  now_ms_i,
  output logic                  fire_o,
  output logic [CountWidth-1:0] total_o
);

  logic [TimeWidth-1:0]  last_fire_q, last_fire_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  new_in_band;
  logic                  prev_in_band;
  logic                  hit;
  logic [TimeWidth-1:0]  elapsed;

  always_comb begin
    new_in_band  = (level_i >= cfg_i.band_low) && (level_i <= cfg_i.band_high);
    prev_in_band = (prev_level_i >= cfg_i.band_low) && (prev_level_i <= cfg_i.band_high);
    if (cfg_i.continuous_mode) begin
      hit = (level_i != prev_level_i);
    end else begin
      hit = new_in_band && !prev_in_band;
    end
    elapsed = now_ms_i - last_fire_q;
    fire_o  = in_range_i && hit && (elapsed >= cfg_i.cooldown_ms);
    total_o = fire_o ? count_q + CountWidth'(1) : count_q;
    last_fire_d = last_fire_q;
    count_d     = count_q;
    if (advance_i && fire_o) begin
      last_fire_d = now_ms_i;
      count_d     = total_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fire_q <= '0;
      count_q     <= '0;
    end else begin
      last_fire_q <= last_fire_d;
      count_q     <= count_d;
    end
  end

endmodule

/* rtl/core/channel_band_entry_trigger.sv */
// ----------------------------------------------------------------------------
// channel_band_entry_trigger
// Watches one rule over a stream of lighting channel values and reports a
// fire on band entry or, in continuous mode, on any change of value.
//
// Usage: each input transaction carries a channel number, its level and a
// millisecond time stamp; each one yields exactly one output transaction
// with the fire flag, the firing channel and level (zero when not fired)
// and the running fire count. Registers are written over the configuration
// channel, which is always ready; the user must write them only while the
// block is idle, which the block does not enforce. Each accepted transaction
// is registered in the internal stage and then in the output register. One
// is accepted per cycle unless the RAM clear or a stall holds the input: the
// stored level is read from the RAM at acceptance and written back as the
// item leaves the internal stage, with a bypass for an item that follows one
// on the same channel. After reset the RAM is cleared one entry a cycle and
// the input accepts nothing until that ends. On a receiver stall the output
// register holds; the input keeps accepting until the single stage is full.
// ----------------------------------------------------------------------------
module channel_band_entry_trigger
  import cbet_pkg::*;
#(
  parameter int unsigned MAX_RANGE = MaxRange
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ChannelWidth-1:0] channel_i,
  input  logic [LevelWidth-1:0]   level_i,
  input  logic [TimeWidth-1:0]    now_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    fired_o,
  output logic [ChannelWidth-1:0] fire_channel_o,
  output logic [LevelWidth-1:0]   fire_level_o,
  output logic [CountWidth-1:0]   fire_total_o
);

  localparam int unsigned AddrWidth = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
  localparam logic [ChannelWidth-1:0] RangeLimit = ChannelWidth'(MAX_RANGE);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(MAX_RANGE - 1);

  cfg_t cfg;

  cbet_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic                 clr_q, clr_d;
  logic [AddrWidth-1:0] clr_addr_q, clr_addr_d;

  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_in_range_q;
  logic [AddrWidth-1:0]    s1_addr_q;
  logic [ChannelWidth-1:0] s1_channel_q;
  logic [LevelWidth-1:0]   s1_level_q;
  logic [TimeWidth-1:0]    s1_now_q;
  logic                    byp_hit_q;
  logic [LevelWidth-1:0]   byp_data_q;

  logic                    out_valid_q, out_valid_d;
  logic                    fired_q;
  logic [ChannelWidth-1:0] fire_channel_q;
  logic [LevelWidth-1:0]   fire_level_q;
  logic [CountWidth-1:0]   fire_total_q;

  logic                  accept;
  logic                  s1_adv;
  logic [ChannelWidth:0] offset;
  logic                  in_range;
  logic [AddrWidth-1:0]  in_addr;
  logic                  ram_we;
  logic [AddrWidth-1:0]  ram_waddr;
  logic [LevelWidth-1:0] ram_wdata;
  logic [LevelWidth-1:0] ram_rdata;
  logic [LevelWidth-1:0] prev_level;
  logic                  fire;
  logic [CountWidth-1:0] total;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    offset   = {1'b0, channel_i} - {1'b0, cfg.first_channel};
    in_range = cfg.rule_enabled && !offset[ChannelWidth]
               && (channel_i <= cfg.last_channel)
               && (offset[ChannelWidth-1:0] < RangeLimit);
    in_addr  = offset[AddrWidth-1:0];
  end

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_in_range_q;
      ram_waddr = s1_addr_q;
      ram_wdata = s1_level_q;
    end
  end

  cbet_ram #(
    .Width (LevelWidth),
    .Depth (MAX_RANGE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign prev_level = byp_hit_q ? byp_data_q : ram_rdata;

  cbet_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .advance_i    (s1_adv),
    .in_range_i   (s1_in_range_q),
    .level_i      (s1_level_q),
    .prev_level_i (prev_level),
    .now_ms_i     (s1_now_q),
    .fire_o       (fire),
    .total_o      (total)
  );

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrWidth'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
    s1_valid_d = accept || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
      s1_channel_q  <= channel_i;
      s1_level_q    <= level_i;
      s1_now_q      <= now_ms_i;
      byp_hit_q     <= s1_adv && s1_in_range_q && (s1_addr_q == in_addr);
      byp_data_q    <= s1_level_q;
    end
    if (s1_adv) begin
      fired_q        <= fire;
      fire_channel_q <= fire ? s1_channel_q : '0;
      fire_level_q   <= fire ? s1_level_q : '0;
      fire_total_q   <= total;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fired_o        = fired_q;
  assign fire_channel_o = fire_channel_q;
  assign fire_level_o   = fire_level_q;
  assign fire_total_o   = fire_total_q;

endmodule
